@@ hw/rtl/oltp_pkg.sv @@
// ----------------------------------------------------------------------------
// oltp_pkg
// Shared types and codes for the option list TLV parser.
// ----------------------------------------------------------------------------
package oltp_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_ID_HI   = 3'd1,
		PH_ID_LO   = 3'd2,
		PH_LEN     = 3'd3,
		PH_CONTENT = 3'd4,
		PH_DRAIN   = 3'd5
	} phase_t;

	// End-of-element status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TRUNC    = 3'd1;
	localparam logic [2:0] ST_OVERRUN  = 3'd2;
	localparam logic [2:0] ST_TOO_MANY = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;

	// Result kinds
	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Up to two results caused by one input octet: a descriptor and a status
	typedef struct packed {
		logic        desc_v;
		logic        stat_v;
		logic        ext_bit;
		logic [2:0]  config_protocol;
		logic [3:0]  entry_index;
		logic [15:0] option_id;
		logic [7:0]  content_length;
		logic [11:0] content_offset;
		logic [2:0]  status;
		logic [12:0] total_bytes;
		logic [4:0]  entry_total;
	} pair_t;

endpackage

@@ hw/rtl/oltp_parse.sv @@
// ----------------------------------------------------------------------------
// oltp_parse
// Parser state and per-octet update; builds the results of one octet.
// ----------------------------------------------------------------------------
module oltp_parse #(
	parameter int MAX_ENTRIES     = 16,
	parameter int MAX_FRAME_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic              last_byte,
	output oltp_pkg::pair_t   res
);
	import oltp_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int EC_W  = $clog2(MAX_ENTRIES + 1);

	phase_t             ph_q, ph_d;
	logic [CNT_W-1:0]   bc_q, bc_d;
	logic [EC_W-1:0]    ec_q, ec_d;
	logic [7:0]         idh_q, idh_d;
	logic [15:0]        cid_q, cid_d;
	logic [7:0]         cl_q, cl_d;
	logic [7:0]         hdr_q, hdr_d;
	logic [2:0]         err_q, err_d;
	logic [7:0]         cl_dec;
	logic               fault;
	logic [2:0]         fcode;
	logic [2:0]         err_f;

	always_comb begin
		ph_d   = ph_q;
		bc_d   = bc_q;
		ec_d   = ec_q;
		idh_d  = idh_q;
		cid_d  = cid_q;
		cl_d   = cl_q;
		hdr_d  = hdr_q;
		fault  = 1'b0;
		fcode  = ST_OK;
		cl_dec = cl_q - 8'd1;
		res    = '0;

		if (bc_q >= CNT_W'(MAX_FRAME_BYTES)) begin
			bc_d  = CNT_W'(MAX_FRAME_BYTES);
			fault = 1'b1;
			fcode = ST_TOO_LONG;
		end else begin
			bc_d = bc_q + CNT_W'(1);
			case (ph_q)
				PH_HEADER: begin
					hdr_d = byte_in;
					ph_d  = PH_ID_HI;
				end
				PH_ID_HI: begin
					if (ec_q >= EC_W'(MAX_ENTRIES)) begin
						fault = 1'b1;
						fcode = ST_TOO_MANY;
					end else begin
						idh_d = byte_in;
						ph_d  = PH_ID_LO;
						if (last_byte) begin
							fault = 1'b1;
							fcode = ST_TRUNC;
						end
					end
				end
				PH_ID_LO: begin
					cid_d = {idh_q, byte_in};
					ph_d  = PH_LEN;
					if (last_byte) begin
						fault = 1'b1;
						fcode = ST_TRUNC;
					end
				end
				PH_LEN: begin
					cl_d               = byte_in;
					res.desc_v         = 1'b1;
					res.entry_index    = 4'(ec_q);
					res.option_id      = cid_q;
					res.content_length = byte_in;
					res.content_offset = 12'(bc_d);
					ec_d               = ec_q + EC_W'(1);
					ph_d               = (byte_in != 8'd0) ? PH_CONTENT : PH_ID_HI;
					if (last_byte && byte_in != 8'd0) begin
						fault = 1'b1;
						fcode = ST_OVERRUN;
					end
				end
				PH_CONTENT: begin
					cl_d = cl_dec;
					if (cl_dec == 8'd0) begin
						ph_d = PH_ID_HI;
					end else if (last_byte) begin
						fault = 1'b1;
						fcode = ST_OVERRUN;
					end
				end
				default: begin
				end
			endcase
		end

		// first error sticks; any fault drops the rest of the element
		err_f = err_q;
		if (fault) begin
			if (err_q == ST_OK) begin
				err_f = fcode;
			end
			ph_d = PH_DRAIN;
		end
		err_d = err_f;

		res.ext_bit         = hdr_d[7];
		res.config_protocol = hdr_d[2:0];

		if (last_byte) begin
			res.stat_v      = 1'b1;
			res.status      = err_f;
			res.total_bytes = 13'(bc_d);
			res.entry_total = 5'(ec_d);
			ph_d            = PH_HEADER;
			bc_d            = '0;
			ec_d            = '0;
			cl_d            = '0;
			err_d           = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HEADER;
			bc_q  <= '0;
			ec_q  <= '0;
			idh_q <= '0;
			cid_q <= '0;
			cl_q  <= '0;
			hdr_q <= '0;
			err_q <= ST_OK;
		end else if (step) begin
			ph_q  <= ph_d;
			bc_q  <= bc_d;
			ec_q  <= ec_d;
			idh_q <= idh_d;
			cid_q <= cid_d;
			cl_q  <= cl_d;
			hdr_q <= hdr_d;
			err_q <= err_d;
		end
	end

endmodule

@@ hw/rtl/option_list_tlv_parser.sv @@
// ----------------------------------------------------------------------------
// option_list_tlv_parser
// Streaming parser for a protocol configuration options element, one octet
// per request; reports entry descriptors and an end-of-element status.
// ----------------------------------------------------------------------------
// Path: an accepted octet passes the input register, then the result register,
//   from which its result is presented until it is taken.
// Throughput: one octet per cycle while the result register can take results;
//   an octet yielding a descriptor and a status holds it until both are taken.
// Reset: arst_n clears parser state and all valid flags asynchronously.
module option_list_tlv_parser #(
	parameter int MAX_ENTRIES     = 16,
	parameter int MAX_FRAME_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input octet channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        last_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [3:0]  entry_index,
	output logic [15:0] option_id,
	output logic [7:0]  content_length,
	output logic [11:0] content_offset,
	output logic        ext_bit,
	output logic [2:0]  config_protocol,
	output logic [2:0]  status,
	output logic [12:0] total_bytes,
	output logic [4:0]  entry_total,
	output logic        last_result
);
	import oltp_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Result register: pending flags with reset, payload without
	logic       desc_q;
	logic       stat_q;
	pair_t      res_q;

	pair_t      new_res;
	logic       has_res;
	logic       out_take;
	logic       res_free;
	logic       s1_adv;
	logic       step;

	oltp_parse #(
		.MAX_ENTRIES     (MAX_ENTRIES),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.last_byte (last_s1),
		.res       (new_res)
	);

	// Handshake and flow control. The octet in the input register may move on
	// when it produces nothing, or when the result register is empty or is
	// handing over its final pending result this cycle.
	assign has_res  = new_res.desc_v | new_res.stat_v;
	assign out_take = out_valid & out_ready;
	assign res_free = !(desc_q | stat_q) | (out_take & (desc_q ^ stat_q));
	assign s1_adv   = !has_res | res_free;
	assign step     = valid_s1 & s1_adv;
	assign in_ready = !valid_s1 | s1_adv;

	// Input register: load on accept, drop once the octet has been parsed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			last_s1 <= last_byte;
		end
	end

	// Result register: the descriptor goes out first, then the status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
			stat_q <= 1'b0;
		end else if (step && has_res) begin
			desc_q <= new_res.desc_v;
			stat_q <= new_res.stat_v;
		end else if (out_take) begin
			if (desc_q) begin
				desc_q <= 1'b0;
			end else begin
				stat_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_res) begin
			res_q <= new_res;
		end
	end

	// Output selection: zero the fields that do not belong to the shown kind
	always_comb begin
		out_valid       = desc_q | stat_q;
		kind            = desc_q ? KIND_ENTRY : KIND_STATUS;
		ext_bit         = res_q.ext_bit;
		config_protocol = res_q.config_protocol;
		entry_index     = '0;
		option_id       = '0;
		content_length  = '0;
		content_offset  = '0;
		status          = ST_OK;
		total_bytes     = '0;
		entry_total     = '0;
		if (desc_q) begin
			entry_index    = res_q.entry_index;
			option_id      = res_q.option_id;
			content_length = res_q.content_length;
			content_offset = res_q.content_offset;
			last_result    = !stat_q;
		end else begin
			status         = res_q.status;
			total_bytes    = res_q.total_bytes;
			entry_total    = res_q.entry_total;
			last_result    = 1'b1;
		end
	end

`ifndef SYNTHESIS
	// A taken descriptor with a status behind it is followed by that status
	a_stat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && desc_q && stat_q) |=> (out_valid && kind == KIND_STATUS))
		else $error("status result lost after descriptor");

	// A held octet that cannot move on blocks new requests
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |-> !in_ready)
		else $error("input accepted while input register stalled");

	// A pending result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(step && has_res) |-> (!(desc_q | stat_q) || (out_take && (desc_q ^ stat_q))))
		else $error("result register overwritten");
`endif

endmodule
